/* src/asd_pkg.sv */
// ----------------------------------------------------------------------------
// asd_pkg
// Shared types, widths and constants of the adaptive spectral denoiser.
// ----------------------------------------------------------------------------
package asd_pkg;

  localparam int DEF_MAX_HARMONICS = 64;
  localparam int SAMPLE_W = 24;
  localparam int POWER_W = 47;
  localparam int GAIN_W = 17;
  localparam int SUM_W = 54;
  localparam int MERIT_W = 64;
  localparam int IDX_W = 6;

  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;
  localparam logic [POWER_W-1:0] POWER_MAX = {POWER_W{1'b1}};

  localparam logic [1:0] REG_FILTER_MODE = 2'd0;
  localparam logic [1:0] REG_NOISE_BAND = 2'd1;
  localparam logic [1:0] REG_HOLD_GAINS = 2'd2;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_GAIN_RD,
    ST_GAIN_CALC,
    ST_DIV,
    ST_CUT_SEL,
    ST_GAIN_WR,
    ST_OUT_RD,
    ST_OUT_MUL,
    ST_OUT_PUSH
  } asd_state_t;

endpackage

/* src/adaptive_spectral_denoise.sv */
// ----------------------------------------------------------------------------
// adaptive_spectral_denoise
// Wiener or brick-wall low-pass filtering of one profile's harmonics.
// ----------------------------------------------------------------------------
// channel   dir  handshake                 payload
// in        in   in_valid / in_ready       harm_real, harm_imag, last_harmonic
// out       out  out_valid / out_ready     out_real, out_imag, harmonic_index,
//                                          cutoff_harmonic, last_result
// cfg       in   cfg_we                    cfg_index, cfg_data
//
// loading registers each item's power, then writes it; no new item is taken
// while one is pending. after the last item: a walk for the noise sum, then a
// gain step per harmonic (sinc, or wiener without division, or wiener through
// the bit-serial divider), then one result per output step, held while
// out_ready is low; the memory port is shared by all walks.
// reset clears control state only; stores hold anything until written.
// a stalled output holds the walk; no input item is taken during a run.
module adaptive_spectral_denoise #(
  parameter int MAX_HARMONICS = asd_pkg::DEF_MAX_HARMONICS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [23:0]            harm_real,
  input  logic signed [23:0]            harm_imag,
  input  logic                          last_harmonic,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [23:0]            out_real,
  output logic signed [23:0]            out_imag,
  output logic [5:0]                    harmonic_index,
  output logic [5:0]                    cutoff_harmonic,
  output logic                          last_result,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [8:0]                    cfg_data
);
  import asd_pkg::*;

  localparam int AW = $clog2(MAX_HARMONICS);
  localparam int CW = $clog2(MAX_HARMONICS + 1);
  localparam int DW = 2 * SAMPLE_W + POWER_W;

  asd_state_t state, state_next;

  logic       filter_mode;
  logic [8:0] noise_band_q8;
  logic       hold_gains;

  logic [CW-1:0] load_count, nh, idx, start_idx, gain_count, cnt_c;
  logic          gains_valid;
  logic          gains_sinc;
  logic [5:0]    cutoff_reg;
  logic          pend_last, pend_keep;
  logic [SAMPLE_W-1:0] pend_re, pend_im;
  logic [POWER_W-1:0]  pend_p;

  // sample/power memory and gain memory
  logic          d_we;
  logic [AW-1:0] d_wa, d_ra;
  logic [DW-1:0] d_wd, d_rd;
  logic          g_we;
  logic [AW-1:0] g_wa, g_ra;
  logic [GAIN_W-1:0] g_wd, g_rd;

  asd_ram #(.WIDTH(DW), .DEPTH(MAX_HARMONICS)) u_data (
    .clk(clk), .wr_en(d_we), .wr_addr(d_wa), .wr_data(d_wd),
    .rd_addr(d_ra), .rd_data(d_rd)
  );
  asd_ram #(.WIDTH(GAIN_W), .DEPTH(MAX_HARMONICS)) u_gain (
    .clk(clk), .wr_en(g_we), .wr_addr(g_wa), .wr_data(g_wd),
    .rd_addr(g_ra), .rd_data(g_rd)
  );

  logic [POWER_W-1:0] rd_p;
  logic signed [SAMPLE_W-1:0] rd_re, rd_im;
  assign rd_re = d_rd[DW-1 -: SAMPLE_W];
  assign rd_im = d_rd[POWER_W +: SAMPLE_W];
  assign rd_p  = d_rd[POWER_W-1:0];

  logic [SUM_W-1:0] sum_s, sum_r;
  logic signed [MERIT_W-1:0] best_m, merit;
  logic [5:0] best_k;
  logic [MERIT_W-1:0] den, num, div_num;
  logic [GAIN_W-1:0] gain_val;
  logic div_start, div_done;
  logic [GAIN_W-1:0] div_q;

  asd_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(den),
    .done(div_done), .quot(div_q)
  );

  // input power, registered before the memory write
  logic [2*SAMPLE_W-1:0] sq_re, sq_im;
  logic [POWER_W:0] p_full;
  assign sq_re = 48'($signed(harm_real) * $signed(harm_real));
  assign sq_im = 48'($signed(harm_imag) * $signed(harm_imag));
  assign p_full = sq_re[POWER_W:0] + sq_im[POWER_W:0];

  logic [8:0] nb;
  logic [17:0] start_prod;
  assign nb = (noise_band_q8 > 9'd256) ? 9'd256 : noise_band_q8;
  assign start_prod = 18'((9'd256 - nb) * 18'(nh));

  logic in_acc, out_acc;
  assign in_ready = (state == ST_LOAD) && !pend_keep;
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;

  logic signed [MERIT_W-1:0] cs_s;
  assign cs_s = $signed({{(MERIT_W-CW){1'b0}}, (cnt_c == '0) ? CW'(1) : cnt_c});

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode   <= 1'b1;
      noise_band_q8 <= 9'd77;
      hold_gains    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FILTER_MODE: filter_mode   <= cfg_data[0];
        REG_NOISE_BAND:  noise_band_q8 <= cfg_data;
        REG_HOLD_GAINS:  hold_gains    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    d_we = 1'b0; d_wa = AW'(load_count); d_wd = {pend_re, pend_im, pend_p};
    d_ra = AW'(idx); g_we = 1'b0; g_wa = AW'(idx); g_wd = gain_val;
    g_ra = AW'(idx); div_start = 1'b0;
    unique case (state)
      ST_LOAD: begin
        if (pend_keep && load_count < CW'(MAX_HARMONICS)) d_we = 1'b1;
        if (pend_keep && pend_last) begin
          if (hold_gains && gains_valid) state_next = ST_OUT_RD;
          else state_next = ST_SUM_RD;
        end
      end
      ST_SUM_RD:  state_next = (idx >= nh) ? ST_GAIN_RD : ST_SUM_ACC;
      ST_SUM_ACC: state_next = ST_SUM_RD;
      ST_GAIN_RD: state_next = (idx >= nh) ? ST_OUT_RD : ST_GAIN_CALC;
      ST_GAIN_CALC: begin
        if (!filter_mode && idx != '0 && rd_p != '0 &&
            den >= {num[MERIT_W-2:0], 1'b0}) begin
          state_next = ST_DIV;
        end else begin
          state_next = filter_mode ? ST_CUT_SEL : ST_GAIN_WR;
        end
        div_start = (state_next == ST_DIV);
      end
      ST_DIV:     if (div_done) state_next = ST_GAIN_WR;
      ST_CUT_SEL: state_next = (idx >= nh) ? ST_GAIN_WR : ST_GAIN_RD;
      ST_GAIN_WR: begin
        g_we = (idx < nh);
        state_next = ST_GAIN_RD;
      end
      ST_OUT_RD:  state_next = (idx >= nh) ? ST_LOAD : ST_OUT_MUL;
      ST_OUT_MUL: state_next = ST_OUT_PUSH;
      ST_OUT_PUSH: if (!out_valid || out_acc) state_next = ST_OUT_RD;
      default: state_next = ST_LOAD;
    endcase
  end

  // wiener numbers: den = c*p, num = S (checked den >= 2S), ratio (den-S)/den
  logic [MERIT_W-1:0] cp;
  assign cp = MERIT_W'(rd_p) * MERIT_W'(cnt_c == '0 ? CW'(1) : cnt_c);
  assign den = cp;
  assign num = MERIT_W'(sum_s);
  assign div_num = den - num;

  logic signed [SAMPLE_W+GAIN_W:0] pr_re, pr_im;
  logic [GAIN_W-1:0] cur_g;
  logic [5:0] out_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count  <= '0;
      gains_valid <= 1'b0;
      gains_sinc  <= 1'b0;
      cutoff_reg  <= '0;
      gain_count  <= '0;
      pend_keep   <= 1'b0;
      out_valid   <= 1'b0;
      idx         <= '0;
    end else begin
      if (out_acc) out_valid <= 1'b0;
      unique case (state)
        ST_LOAD: begin
          if (in_acc) begin
            pend_keep <= 1'b1;
            pend_last <= last_harmonic;
            pend_re   <= harm_real;
            pend_im   <= harm_imag;
            pend_p    <= p_full[POWER_W] ? POWER_MAX : p_full[POWER_W-1:0];
          end else if (pend_keep) begin
            pend_keep <= 1'b0;
            if (pend_last) begin
              nh <= (load_count < CW'(MAX_HARMONICS)) ? load_count + CW'(1)
                                                      : load_count;
              load_count <= '0;
              idx   <= '0;
              sum_s <= '0;
              sum_r <= '0;
            end else if (load_count < CW'(MAX_HARMONICS)) begin
              load_count <= load_count + CW'(1);
            end
          end
          if (pend_keep && pend_last) begin
            start_idx <= '0;
          end
        end
        ST_SUM_RD: begin
          if (idx == '0) begin
            start_idx <= CW'(start_prod >> 8);
            cnt_c <= nh - CW'(start_prod >> 8);
          end
          if (idx >= nh) begin
            idx <= '0;
            best_k <= '0;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        ST_SUM_ACC: begin
          if ((idx - CW'(1)) >= start_idx) sum_s <= sum_s + SUM_W'(rd_p);
          if ((idx - CW'(1)) != '0) sum_r <= sum_r + SUM_W'(rd_p);
        end
        ST_GAIN_RD: begin
          if (idx >= nh) begin
            gain_count  <= nh;
            gains_valid <= 1'b1;
            gains_sinc  <= filter_mode;
            if (filter_mode) cutoff_reg <= best_k;
            idx <= '0;
          end
        end
        ST_GAIN_CALC: begin
          if (idx == '0) gain_val <= GAIN_ONE;
          else if (filter_mode) begin
            // merit of cutoff idx after removing its power from the tail
            sum_r <= sum_r - SUM_W'(rd_p);
          end else begin
            gain_val <= '0;
            if (cp >= num) gain_val <= '0;
          end
        end
        ST_DIV: if (div_done) gain_val <= div_q;
        ST_CUT_SEL: begin
          if (idx != '0 && (idx == CW'(1) || merit < best_m)) begin
            best_m <= merit;
            best_k <= 6'(idx);
          end
          if (idx != '0) gain_val <= GAIN_ONE;
          idx <= idx + CW'(1);
        end
        ST_GAIN_WR: begin
          if (!filter_mode) idx <= idx + CW'(1);
        end
        ST_OUT_RD: if (idx >= nh) idx <= '0;
        ST_OUT_MUL: ;
        ST_OUT_PUSH: begin
          if (!out_valid || out_acc) begin
            out_valid      <= 1'b1;
            out_real       <= SAMPLE_W'(pr_re >>> 16);
            out_imag       <= SAMPLE_W'(pr_im >>> 16);
            harmonic_index <= out_idx;
            cutoff_harmonic <= cutoff_reg;
            last_result    <= (idx + CW'(1) == nh);
            idx <= idx + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign merit = $signed(MERIT_W'(idx)) * $signed(MERIT_W'(sum_s))
               + cs_s * $signed(MERIT_W'(sum_r))
               - $signed(MERIT_W'(nh - CW'(1) - idx)) * $signed(MERIT_W'(sum_s));

  always_ff @(posedge clk) begin
    if (state == ST_OUT_MUL) begin
      pr_re <= $signed(rd_re) * $signed({1'b0, cur_g});
      pr_im <= $signed(rd_im) * $signed({1'b0, cur_g});
      out_idx <= 6'(idx);
    end
  end

  // brick-wall gains follow from the kept cutoff; the gain store holds wiener gains
  assign cur_g = (idx >= gain_count) ? '0 :
                 gains_sinc ? ((6'(idx) <= cutoff_reg) ? GAIN_ONE : '0) : g_rd;

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid || state == ST_LOAD) else $error("load during run");
  assert property (@(posedge clk) disable iff (rst)
    gains_valid |-> gain_count != '0) else $error("empty gain set");
endmodule

/* src/asd_ram.sv */
// ----------------------------------------------------------------------------
// asd_ram
// Generic single-port-write, single-port-read memory with registered read.
// ----------------------------------------------------------------------------
module asd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

/* src/asd_div.sv */
// ----------------------------------------------------------------------------
// asd_div
// Restoring divider: 16 fraction bits of num/den, one bit per cycle.
// ----------------------------------------------------------------------------
module asd_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [asd_pkg::MERIT_W-1:0]  num,
  input  logic [asd_pkg::MERIT_W-1:0]  den,
  output logic                         done,
  output logic [asd_pkg::GAIN_W-1:0]   quot
);
  import asd_pkg::*;

  logic [MERIT_W:0]   rem;
  logic [MERIT_W-1:0] dvs;
  logic [15:0]        q;
  logic [4:0]         cnt;
  logic               busy;
  logic               sat;
  logic [MERIT_W:0]   shifted;

  assign shifted = {rem[MERIT_W-1:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= {1'b0, num};
        dvs  <= den;
        q    <= '0;
        // a ratio of one or more gives unity gain
        sat  <= (num >= den);
      end else if (busy) begin
        if (shifted >= {1'b0, dvs}) begin
          rem <= shifted - {1'b0, dvs};
          q   <= {q[14:0], 1'b1};
        end else begin
          rem <= shifted;
          q   <= {q[14:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = sat ? GAIN_ONE : {1'b0, q};
endmodule
